FILE: rtl/core/trisn_pkg.sv
// Shared types and constants for the triangle subdivision and face normal block.
package trisn_pkg;

    localparam int CW        = 16;
    localparam int FRAC_BITS = 14;

    // Signed width that holds a cross product of edge differences.
    localparam int VEC_W = 2 * CW + 3;

    // Normalizer geometry: magnitudes are aligned so the largest has its top bit at NRM_W-1.
    localparam int NRM_W    = 30;
    localparam int ROOT_W   = NRM_W + 2;
    localparam int QW       = FRAC_BITS + 2;
    localparam int SQ_PER   = 2;
    localparam int SQ_ST    = ROOT_W / SQ_PER;
    localparam int DV_PER   = 2;
    localparam int DV_ST    = QW / DV_PER;
    localparam int NORM_LAT = 5 + SQ_ST + 1 + DV_ST + 1;

    localparam int COORD_MAX = (1 <<< (CW - 1)) - 1;
    localparam int COORD_MIN = -COORD_MAX - 1;

    localparam int N_SUB  = 12;
    localparam int N_PASS = 3;
    localparam int CNT_W  = $clog2(N_SUB + 1);
    localparam int IDX_W  = $clog2(N_SUB);

    typedef logic signed [VEC_W-1:0] wide_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 deg;
    } vtx_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [CW-1:0] vert_x;
        logic signed [CW-1:0] vert_y;
        logic signed [CW-1:0] vert_z;
        logic signed [CW-1:0] norm_x;
        logic signed [CW-1:0] norm_y;
        logic signed [CW-1:0] norm_z;
        logic                 degenerate;
        logic                 last_vertex;
    } tri_out_t;

endpackage

FILE: rtl/core/trisn_norm.sv
// Pipelined vector normalizer: align, sum of squares, square root, per-component divide.
module trisn_norm
    import trisn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  wide_t vec [3],
    output logic  out_valid,
    output vtx_t  unit
);

    localparam int MAG_W = VEC_W - 1;
    localparam int POS_W = $clog2(MAG_W);
    localparam int SQ_W  = 2 * NRM_W;
    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 4;
    localparam int NUM_W = NRM_W + FRAC_BITS + 1;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [X_W-1:0]    x;
    } sq_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QW-1:0]     lo;
        logic [QW-1:0]     q;
    } dv_t;

    function automatic logic [POS_W-1:0] lead_pos(logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [NRM_W-1:0] align(logic [MAG_W-1:0] m, logic [POS_W-1:0] p);
        logic [MAG_W-1:0] s;
        if (p >= POS_W'(NRM_W - 1)) begin
            s = m >> (p - POS_W'(NRM_W - 1));
        end
        else begin
            s = m << (POS_W'(NRM_W - 1) - p);
        end
        return s[NRM_W-1:0];
    endfunction

    // Two digits of the restoring square root per stage.
    function automatic sq_t sq_stage(sq_t s);
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] trial;
        sq_t o;
        o = s;
        for (int j = 0; j < SQ_PER; j++) begin
            r2    = {o.rem[REM_W-3:0], o.x[X_W-1:X_W-2]};
            trial = {{(REM_W - ROOT_W - 2){1'b0}}, o.root, 2'b01};
            o.x   = {o.x[X_W-3:0], 2'b00};
            if (r2 >= trial) begin
                o.rem  = r2 - trial;
                o.root = {o.root[ROOT_W-2:0], 1'b1};
            end
            else begin
                o.rem  = r2;
                o.root = {o.root[ROOT_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Two quotient bits of the restoring divide per stage.
    function automatic dv_t dv_stage(dv_t d, logic [ROOT_W-1:0] len);
        logic [ROOT_W:0] r2;
        dv_t o;
        o = d;
        for (int j = 0; j < DV_PER; j++) begin
            r2   = {o.rem, o.lo[QW-1]};
            o.lo = {o.lo[QW-2:0], 1'b0};
            if (r2 >= {1'b0, len}) begin
                r2  = r2 - {1'b0, len};
                o.q = {o.q[QW-2:0], 1'b1};
            end
            else begin
                o.q = {o.q[QW-2:0], 1'b0};
            end
            o.rem = r2[ROOT_W-1:0];
        end
        return o;
    endfunction

    function automatic logic signed [CW-1:0] to_coord(logic [QW-1:0] q, logic neg);
        int v;
        v = neg ? -int'(q) : int'(q);
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN) begin
            v = COORD_MIN;
        end
        return CW'(v);
    endfunction

    logic [NORM_LAT-1:0] vld_reg;
    logic [NORM_LAT-1:0] vld_next;

    logic [MAG_W-1:0]  m1_reg [3];
    logic [MAG_W-1:0]  m2_reg [3];
    logic [NRM_W-1:0]  m3_reg [3];
    logic [NRM_W-1:0]  m4_reg [3];
    logic [SQ_W-1:0]   sq4_reg [3];
    logic [2:0]        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic              zero2_reg, zero3_reg, zero4_reg;

    sq_t               sq_reg [SQ_ST+1];
    logic [NRM_W-1:0]  sm_reg [SQ_ST+1][3];
    logic [2:0]        sn_reg [SQ_ST+1];
    logic              sz_reg [SQ_ST+1];

    dv_t               dv_init [3];
    dv_t               dv_reg [DV_ST+1][3];
    logic [ROOT_W-1:0] dlen_reg [DV_ST+1];
    logic [2:0]        dn_reg [DV_ST+1];
    logic              dz_reg [DV_ST+1];

    vtx_t              unit_reg;

    logic [MAG_W-1:0]  mag_or;
    logic [NUM_W-1:0]  num [3];

    assign vld_next  = {vld_reg[NORM_LAT-2:0], in_valid};
    assign out_valid = vld_reg[NORM_LAT-1];
    assign unit      = unit_reg;
    assign mag_or    = m1_reg[0] | m1_reg[1] | m1_reg[2];

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NUM_W'(sm_reg[SQ_ST][i]) << FRAC_BITS)
                   + NUM_W'(sq_reg[SQ_ST].root >> 1);
            dv_init[i].rem = ROOT_W'(num[i] >> QW);
            dv_init[i].lo  = num[i][QW-1:0];
            dv_init[i].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            m1_reg[i]   <= vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
            neg1_reg[i] <= vec[i][VEC_W-1];
            m2_reg[i]   <= m1_reg[i];
            m3_reg[i]   <= align(m2_reg[i], pos2_reg);
            m4_reg[i]   <= m3_reg[i];
            sq4_reg[i]  <= SQ_W'(m3_reg[i]) * SQ_W'(m3_reg[i]);
            sm_reg[0][i] <= m4_reg[i];
        end
        neg2_reg  <= neg1_reg;
        pos2_reg  <= lead_pos(mag_or);
        zero2_reg <= (mag_or == '0);
        neg3_reg  <= neg2_reg;
        zero3_reg <= zero2_reg;
        neg4_reg  <= neg3_reg;
        zero4_reg <= zero3_reg;

        sq_reg[0].rem  <= '0;
        sq_reg[0].root <= '0;
        sq_reg[0].x    <= X_W'(sq4_reg[0]) + X_W'(sq4_reg[1]) + X_W'(sq4_reg[2]);
        sn_reg[0]      <= neg4_reg;
        sz_reg[0]      <= zero4_reg;
        for (int k = 1; k <= SQ_ST; k++) begin
            sq_reg[k] <= sq_stage(sq_reg[k-1]);
            sm_reg[k] <= sm_reg[k-1];
            sn_reg[k] <= sn_reg[k-1];
            sz_reg[k] <= sz_reg[k-1];
        end

        dv_reg[0]   <= dv_init;
        dlen_reg[0] <= sq_reg[SQ_ST].root;
        dn_reg[0]   <= sn_reg[SQ_ST];
        dz_reg[0]   <= sz_reg[SQ_ST];
        for (int k = 1; k <= DV_ST; k++) begin
            for (int i = 0; i < 3; i++) begin
                dv_reg[k][i] <= dv_stage(dv_reg[k-1][i], dlen_reg[k-1]);
            end
            dlen_reg[k] <= dlen_reg[k-1];
            dn_reg[k]   <= dn_reg[k-1];
            dz_reg[k]   <= dz_reg[k-1];
        end

        // A zero-length vector comes out as zeros with the degenerate mark.
        if (dz_reg[DV_ST]) begin
            unit_reg <= '{x: '0, y: '0, z: '0, deg: 1'b1};
        end
        else begin
            unit_reg.x   <= to_coord(dv_reg[DV_ST][0].q, dn_reg[DV_ST][0]);
            unit_reg.y   <= to_coord(dv_reg[DV_ST][1].q, dn_reg[DV_ST][1]);
            unit_reg.z   <= to_coord(dv_reg[DV_ST][2].q, dn_reg[DV_ST][2]);
            unit_reg.deg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/triangle_subdivide_normals.sv
// Top level: triangle midpoint subdivision with flat unit face normals.
//
// Input channel: a triangle word on item is taken at a rising edge where start is high
// and busy is low. Configuration: cfg_data is written to the subdivide mode bit at an
// edge where cfg_valid and cfg_ready are high; cfg_ready is always high, and the mode
// should only change while no triangle is in flight.
// Output channel: each vertex word is shown on result for exactly one cycle with
// result_valid high. A triangle yields 3 words in pass-through mode and 12 words in
// subdivide mode, on consecutive cycles, the final one marked by last_vertex.
// Path: a triangle passes through two 31-stage normalizer pipelines (midpoints,
// then face normals) plus the input, triangle assembly, edge difference, cross
// product and output registers.
// After an accept, busy holds off the next triangle so that triangles enter no
// faster than the one-word-per-cycle output serializer emits their words.
// Several triangles are in the pipeline at once.
// Reset clears all valid bits, the serializer and the mode bit (pass-through).
// The receiver cannot stall, so nothing is ever held back on the output side.
module triangle_subdivide_normals
    import trisn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tri_in_t  item,
    output logic     result_valid,
    output tri_out_t result,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    typedef logic signed [CW:0]       diff_t;
    typedef logic signed [2*CW+1:0]   prod_t;

    logic              mode_reg;
    logic [CNT_W-1:0]  gap_reg, gap_next;
    logic              accept;

    logic              s_v_reg;
    vtx_t              sa_reg, sb_reg, sc_reg;
    logic              smode_reg;

    wide_t             sum_ab [3];
    wide_t             sum_ac [3];
    wide_t             sum_bc [3];
    vtx_t              mab, mac, mbc;
    logic              mid_v, mid_v_ac, mid_v_bc;

    vtx_t              da_reg [NORM_LAT];
    vtx_t              db_reg [NORM_LAT];
    vtx_t              dc_reg [NORM_LAT];
    logic              dm_reg [NORM_LAT];

    logic              tv_reg, dv_reg, pv_reg;
    vtx_t              tri_reg  [4][3];
    vtx_t              dtri_reg [4][3];
    vtx_t              ptri_reg [4][3];
    logic              tmode_reg, dmode_reg, pmode_reg;
    diff_t             d1_reg [4][3];
    diff_t             d2_reg [4][3];
    prod_t             p_reg  [4][6];

    wide_t             cr [4][3];
    vtx_t              face [4];
    logic              face_v [4];

    vtx_t              ftri_reg [NORM_LAT][4][3];
    logic              fmode_reg [NORM_LAT];

    tri_out_t          ld [N_SUB];
    tri_out_t          hb_reg [N_SUB];
    tri_out_t          res_reg;
    logic              rv_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  left_reg;
    logic              load;
    logic              lmode;

    assign accept       = start && !busy;
    assign busy         = (gap_reg != '0);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    always_comb
    begin
        gap_next = gap_reg;
        if (accept) begin
            gap_next = mode_reg ? CNT_W'(N_SUB - 1) : CNT_W'(N_PASS - 1);
        end
        else if (gap_reg != '0) begin
            gap_next = gap_reg - 1'b1;
        end
    end

    // Midpoints are normalized sums, so no halving is needed.
    assign sum_ab[0] = wide_t'(sa_reg.x) + wide_t'(sb_reg.x);
    assign sum_ab[1] = wide_t'(sa_reg.y) + wide_t'(sb_reg.y);
    assign sum_ab[2] = wide_t'(sa_reg.z) + wide_t'(sb_reg.z);
    assign sum_ac[0] = wide_t'(sa_reg.x) + wide_t'(sc_reg.x);
    assign sum_ac[1] = wide_t'(sa_reg.y) + wide_t'(sc_reg.y);
    assign sum_ac[2] = wide_t'(sa_reg.z) + wide_t'(sc_reg.z);
    assign sum_bc[0] = wide_t'(sb_reg.x) + wide_t'(sc_reg.x);
    assign sum_bc[1] = wide_t'(sb_reg.y) + wide_t'(sc_reg.y);
    assign sum_bc[2] = wide_t'(sb_reg.z) + wide_t'(sc_reg.z);

    trisn_norm u_mab (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_v_reg),
        .vec       (sum_ab),
        .out_valid (mid_v),
        .unit      (mab)
    );

    trisn_norm u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_v_reg),
        .vec       (sum_ac),
        .out_valid (mid_v_ac),
        .unit      (mac)
    );

    trisn_norm u_mbc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_v_reg),
        .vec       (sum_bc),
        .out_valid (mid_v_bc),
        .unit      (mbc)
    );

    always_comb
    begin
        for (int t = 0; t < 4; t++) begin
            cr[t][0] = wide_t'(p_reg[t][0]) - wide_t'(p_reg[t][1]);
            cr[t][1] = wide_t'(p_reg[t][2]) - wide_t'(p_reg[t][3]);
            cr[t][2] = wide_t'(p_reg[t][4]) - wide_t'(p_reg[t][5]);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_face
        trisn_norm u_face (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pv_reg),
            .vec       (cr[g]),
            .out_valid (face_v[g]),
            .unit      (face[g])
        );
    end

    assign load  = face_v[0];
    assign lmode = fmode_reg[NORM_LAT-1];

    always_comb
    begin
        for (int t = 0; t < 4; t++) begin
            for (int j = 0; j < 3; j++) begin
                ld[t*3+j].vert_x      = ftri_reg[NORM_LAT-1][t][j].x;
                ld[t*3+j].vert_y      = ftri_reg[NORM_LAT-1][t][j].y;
                ld[t*3+j].vert_z      = ftri_reg[NORM_LAT-1][t][j].z;
                ld[t*3+j].norm_x      = face[t].x;
                ld[t*3+j].norm_y      = face[t].y;
                ld[t*3+j].norm_z      = face[t].z;
                ld[t*3+j].degenerate  = ftri_reg[NORM_LAT-1][t][j].deg | face[t].deg;
                ld[t*3+j].last_vertex = ((t*3+j) == ((lmode ? N_SUB : N_PASS) - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
            gap_reg  <= '0;
            s_v_reg  <= 1'b0;
            tv_reg   <= 1'b0;
            dv_reg   <= 1'b0;
            pv_reg   <= 1'b0;
            rv_reg   <= 1'b0;
            idx_reg  <= '0;
            left_reg <= '0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            gap_reg <= gap_next;
            s_v_reg <= accept;
            tv_reg  <= mid_v && mid_v_ac && mid_v_bc;
            dv_reg  <= tv_reg;
            pv_reg  <= dv_reg;
            if (load) begin
                rv_reg   <= 1'b1;
                idx_reg  <= IDX_W'(1);
                left_reg <= lmode ? CNT_W'(N_SUB - 1) : CNT_W'(N_PASS - 1);
            end
            else if (left_reg != '0) begin
                rv_reg   <= 1'b1;
                idx_reg  <= idx_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
            end
            else begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            sa_reg    <= '{x: item.a_x, y: item.a_y, z: item.a_z, deg: 1'b0};
            sb_reg    <= '{x: item.b_x, y: item.b_y, z: item.b_z, deg: 1'b0};
            sc_reg    <= '{x: item.c_x, y: item.c_y, z: item.c_z, deg: 1'b0};
            smode_reg <= mode_reg;
        end

        da_reg[0] <= sa_reg;
        db_reg[0] <= sb_reg;
        dc_reg[0] <= sc_reg;
        dm_reg[0] <= smode_reg;
        for (int k = 1; k < NORM_LAT; k++) begin
            da_reg[k] <= da_reg[k-1];
            db_reg[k] <= db_reg[k-1];
            dc_reg[k] <= dc_reg[k-1];
            dm_reg[k] <= dm_reg[k-1];
        end

        // Pass-through uses only the first triangle, built from the original vertices.
        tri_reg[0][0] <= da_reg[NORM_LAT-1];
        tri_reg[0][1] <= dm_reg[NORM_LAT-1] ? mab : db_reg[NORM_LAT-1];
        tri_reg[0][2] <= dm_reg[NORM_LAT-1] ? mac : dc_reg[NORM_LAT-1];
        tri_reg[1][0] <= mab;
        tri_reg[1][1] <= db_reg[NORM_LAT-1];
        tri_reg[1][2] <= mbc;
        tri_reg[2][0] <= mbc;
        tri_reg[2][1] <= dc_reg[NORM_LAT-1];
        tri_reg[2][2] <= mac;
        tri_reg[3][0] <= mab;
        tri_reg[3][1] <= mbc;
        tri_reg[3][2] <= mac;
        tmode_reg     <= dm_reg[NORM_LAT-1];

        for (int t = 0; t < 4; t++) begin
            d1_reg[t][0] <= diff_t'(tri_reg[t][1].x) - diff_t'(tri_reg[t][0].x);
            d1_reg[t][1] <= diff_t'(tri_reg[t][1].y) - diff_t'(tri_reg[t][0].y);
            d1_reg[t][2] <= diff_t'(tri_reg[t][1].z) - diff_t'(tri_reg[t][0].z);
            d2_reg[t][0] <= diff_t'(tri_reg[t][2].x) - diff_t'(tri_reg[t][1].x);
            d2_reg[t][1] <= diff_t'(tri_reg[t][2].y) - diff_t'(tri_reg[t][1].y);
            d2_reg[t][2] <= diff_t'(tri_reg[t][2].z) - diff_t'(tri_reg[t][1].z);

            p_reg[t][0] <= prod_t'(d1_reg[t][1]) * prod_t'(d2_reg[t][2]);
            p_reg[t][1] <= prod_t'(d1_reg[t][2]) * prod_t'(d2_reg[t][1]);
            p_reg[t][2] <= prod_t'(d1_reg[t][2]) * prod_t'(d2_reg[t][0]);
            p_reg[t][3] <= prod_t'(d1_reg[t][0]) * prod_t'(d2_reg[t][2]);
            p_reg[t][4] <= prod_t'(d1_reg[t][0]) * prod_t'(d2_reg[t][1]);
            p_reg[t][5] <= prod_t'(d1_reg[t][1]) * prod_t'(d2_reg[t][0]);
        end
        dtri_reg  <= tri_reg;
        dmode_reg <= tmode_reg;
        ptri_reg  <= dtri_reg;
        pmode_reg <= dmode_reg;

        ftri_reg[0]  <= ptri_reg;
        fmode_reg[0] <= pmode_reg;
        for (int k = 1; k < NORM_LAT; k++) begin
            ftri_reg[k]  <= ftri_reg[k-1];
            fmode_reg[k] <= fmode_reg[k-1];
        end

        if (load) begin
            hb_reg  <= ld;
            res_reg <= ld[0];
        end
        else if (left_reg != '0) begin
            res_reg <= hb_reg[idx_reg];
        end
    end

endmodule

FILE: rtl/core/trisn_check.sv
// Port-level checker for the triangle subdivision block, bound to the top level.
module trisn_check
    import trisn_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     result_valid,
    input tri_out_t result,
    input logic     cfg_valid,
    input logic     cfg_ready
);

    // Every accepted word raises busy, which blocks the next accept.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted word");

    // A face normal that is not degenerate is a unit vector and cannot be all zero.
    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.degenerate) |->
        (result.norm_x != 0 || result.norm_y != 0 || result.norm_z != 0))
        else $error("non-degenerate result carries a zero normal");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write was not taken");

endmodule

bind triangle_subdivide_normals trisn_check u_check (.*);

FILE: tb/triangle_subdivide_normals_checker.sv
// Checker that predicts and compares the vertex words of the subdivision block.
module triangle_subdivide_normals_checker
    import trisn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  tri_in_t  item,
    input  logic     result_valid,
    input  tri_out_t result,
    input  logic     cfg_valid,
    input  logic     cfg_ready,
    input  logic     cfg_data,
    output int       fail_count,
    output int       pending_words,
    output int       words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint c[3];
        bit     deg;
    } pvec_t;

    tri_out_t expected_words[$];
    bit       split_mode;

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic pvec_t unit_vec(longint v0, longint v1, longint v2);
        pvec_t r;
        longint v[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned len;
        longint unsigned q;
        v[0] = v0; v[1] = v1; v[2] = v2;
        mx = 0;
        r.c[0] = 0; r.c[1] = 0; r.c[2] = 0;
        r.deg = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return r;
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + m[i] * m[i];
        len = int_sqrt(acc);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            r.c[i] = clamp_coord(v[i] < 0 ? -longint'(q) : longint'(q));
        end
        r.deg = 1'b0;
        return r;
    endfunction

    // Coordinates are 16 bits, so the edge differences need no truncation.
    function automatic pvec_t flat_normal(pvec_t p, pvec_t q, pvec_t s);
        longint d1[3];
        longint d2[3];
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = q.c[i] - p.c[i];
            d2[i] = s.c[i] - q.c[i];
        end
        return unit_vec(d1[1] * d2[2] - d1[2] * d2[1],
                        d1[2] * d2[0] - d1[0] * d2[2],
                        d1[0] * d2[1] - d1[1] * d2[0]);
    endfunction

    function automatic pvec_t sphere_mid(pvec_t p, pvec_t q);
        return unit_vec(p.c[0] + q.c[0], p.c[1] + q.c[1], p.c[2] + q.c[2]);
    endfunction

    function automatic tri_out_t vertex_word(pvec_t v, pvec_t n);
        tri_out_t w;
        w.vert_x = v.c[0][CW-1:0];
        w.vert_y = v.c[1][CW-1:0];
        w.vert_z = v.c[2][CW-1:0];
        w.norm_x = n.c[0][CW-1:0];
        w.norm_y = n.c[1][CW-1:0];
        w.norm_z = n.c[2][CW-1:0];
        w.degenerate = v.deg | n.deg;
        w.last_vertex = 1'b0;
        return w;
    endfunction

    task automatic queue_triangle(pvec_t p, pvec_t q, pvec_t s);
        pvec_t n;
        n = flat_normal(p, q, s);
        expected_words.push_back(vertex_word(p, n));
        expected_words.push_back(vertex_word(q, n));
        expected_words.push_back(vertex_word(s, n));
    endtask

    task automatic predict_triangle(tri_in_t t);
        pvec_t a, b, c, ab, ac, bc;
        a.c[0] = t.a_x; a.c[1] = t.a_y; a.c[2] = t.a_z; a.deg = 0;
        b.c[0] = t.b_x; b.c[1] = t.b_y; b.c[2] = t.b_z; b.deg = 0;
        c.c[0] = t.c_x; c.c[1] = t.c_y; c.c[2] = t.c_z; c.deg = 0;
        if (!split_mode)
        begin
            queue_triangle(a, b, c);
        end
        else
        begin
            ab = sphere_mid(a, b);
            ac = sphere_mid(a, c);
            bc = sphere_mid(b, c);
            queue_triangle(a, ab, ac);
            queue_triangle(ab, b, bc);
            queue_triangle(bc, c, ac);
            queue_triangle(ab, bc, ac);
        end
        expected_words[$].last_vertex = 1'b1;
    endtask

    task automatic report_mismatch(string what, tri_out_t got, tri_out_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    tri_out_t want_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode <= 1'b0;
            fail_count = 0;
            words_seen = 0;
            pending_words = 0;
        end
        else
        begin
            if (result_valid)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", result, '0);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (result.vert_x !== want_word.vert_x)
                        report_mismatch("vert_x", result, want_word);
                    if (result.vert_y !== want_word.vert_y)
                        report_mismatch("vert_y", result, want_word);
                    if (result.vert_z !== want_word.vert_z)
                        report_mismatch("vert_z", result, want_word);
                    if (result.norm_x !== want_word.norm_x)
                        report_mismatch("norm_x", result, want_word);
                    if (result.norm_y !== want_word.norm_y)
                        report_mismatch("norm_y", result, want_word);
                    if (result.norm_z !== want_word.norm_z)
                        report_mismatch("norm_z", result, want_word);
                    if (result.degenerate !== want_word.degenerate)
                        report_mismatch("degenerate", result, want_word);
                    if (result.last_vertex !== want_word.last_vertex)
                        report_mismatch("last_vertex", result, want_word);
                end
            end
            if (start && !busy)
                predict_triangle(item);
            if (cfg_valid && cfg_ready)
                split_mode <= cfg_data;
            pending_words = expected_words.size();
        end
    end

endmodule

FILE: tb/triangle_subdivide_normals_test.sv
// Testbench top: stimulus, configuration phases and verdict for the subdivision block.
module triangle_subdivide_normals_test;
    import trisn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 90;
    localparam int STALL_LIMIT  = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    tri_in_t  item;
    logic     result_valid;
    tri_out_t result;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;
    int       fail_count;
    int       pending_words;
    int       words_seen;
    int       triangles_sent;
    int       idle_pct;
    int       quiet_cycles;

    triangle_subdivide_normals i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    triangle_subdivide_normals_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_seen    (words_seen)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: any output word, accepted triangle or reset restarts the count.
    always @(posedge clk)
    begin
        if (result_valid || (start && !busy) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d words pending", pending_words);
            $display("FAIL triangle_subdivide_normals");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CW'(COORD_MAX);
            1: return CW'(COORD_MIN);
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Start stays high after an accept until the next call or a drain decides
    // what comes next, so it is written only once per time step.
    task automatic send_triangle(tri_in_t t);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        triangles_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic tri_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
        tri_in_t t;
        t.a_x = CW'(ax); t.a_y = CW'(ay); t.a_z = CW'(az);
        t.b_x = CW'(bx); t.b_y = CW'(by); t.b_z = CW'(bz);
        t.c_x = CW'(cx); t.c_y = CW'(cy); t.c_z = CW'(cz);
        return t;
    endfunction

    task automatic directed_set();
        // Unit axes, extremes, a point triangle, opposite points whose midpoint is zero.
        send_triangle(make_tri(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_triangle(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_triangle(make_tri(COORD_MIN, 0, 0, 0, COORD_MIN, 0, 0, 0, COORD_MIN));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(100, -200, 300, 100, -200, 300, 5, 6, 7));
        send_triangle(make_tri(16384, 0, 0, -16384, 0, 0, 0, 16384, 0));
        send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_triangle(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_triangle(make_tri(COORD_MAX, 0, 0, 0, COORD_MAX, 0, COORD_MIN, COORD_MIN, 0));
    endtask

    task automatic random_phase(int count);
        tri_in_t t;
        for (int n = 0; n < count; n++)
        begin
            t = make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord());
            // Now and then a collapsed edge or opposite vertices.
            case ($urandom_range(0, 9))
                0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end
                1: begin t.c_x = -t.a_x; t.c_y = -t.a_y; t.c_z = -t.a_z; end
                default: ;
            endcase
            send_triangle(t);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        quiet_cycles = 0;
        triangles_sent = 0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        drain();
        write_mode(1'b1);
        directed_set();
        drain();

        idle_pct = 36;
        random_phase(25);
        drain();
        write_mode(1'b0);
        random_phase(25);
        // Hold off until every expected word is back, then carry on.
        drain();
        idle_pct = 76;
        random_phase(25);
        drain();
        write_mode(1'b1);
        random_phase(25);
        drain();
        idle_pct = 0;
        random_phase(25);
        drain();
        write_mode(1'b0);
        random_phase(15);
        drain();

        $display("covered %0d triangles in both modes, %0d vertex words checked",
                 triangles_sent, words_seen);
        if (fail_count == 0)
            $display("PASS triangle_subdivide_normals");
        else
            $display("FAIL triangle_subdivide_normals");
        $finish;
    end

endmodule

FILE: triangle_subdivide_normals.f
rtl/core/trisn_pkg.sv
rtl/core/trisn_norm.sv
rtl/core/triangle_subdivide_normals.sv
rtl/core/trisn_check.sv
tb/triangle_subdivide_normals_checker.sv
tb/triangle_subdivide_normals_test.sv
